>>> hw/rtl/sorted_timer_queue_macros.svh
// assertion macros for the sorted timer queue
`ifndef SORTED_TIMER_QUEUE_MACROS_SVH
`define SORTED_TIMER_QUEUE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define STQ_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define STQ_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/stq_pkg.sv
// shared constants and types for the sorted timer queue
package stq_pkg;

   localparam int DEF_TIMER_SLOTS = 16;
   localparam int DEF_TICK_BITS   = 32;

   localparam int KIND_W   = 2;
   localparam int HANDLE_W = 4;
   localparam int DELAY_W  = 32;
   localparam int STATUS_W = 3;
   localparam int ACT_W    = 5;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ALREADY    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EXPIRED    = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_DECIDE,
      S_INS_RD,
      S_INS_WR,
      S_INS_PUT,
      S_DEL_RD,
      S_DEL_WR,
      S_DEL_FIN,
      S_TICK_RD,
      S_TICK_CMP
   } state_type;

endpackage

>>> hw/rtl/stq_slot_ram.sv
// slot memory: one write port, one registered read port
module stq_slot_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 36
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] slot_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/sorted_timer_queue.sv
// sorted timer queue: tick counter and expiry-ordered timer slots
//
//   channel   ports                                   handshake
//   request   req_kind, req_timer_id, req_delay_ticks start high while busy low
//   result    rsp_status, rsp_expired_id, rsp_last,   rsp_strobe, one cycle
//             rsp_active_count
//
// one shared compare unit walks the slot memory slot by slot, a read and then a compare each.
// insert: scan all timers, shift each later timer up one slot, then place the new one.
// delete: scan all timers, shift each later timer down one slot, then finish.
// tick: check the head (stop at once when empty), removing each expired head by shifting the rest down.
// reset is synchronous; the slot memory is not cleared and needs no sweep.
// results cannot be stalled; busy drops in the cycle that carries the last one.
module sorted_timer_queue #(
   parameter int TIMER_SLOTS = stq_pkg::DEF_TIMER_SLOTS,
   parameter int TICK_BITS   = stq_pkg::DEF_TICK_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [stq_pkg::KIND_W-1:0]    req_kind,
   input  logic [stq_pkg::HANDLE_W-1:0]  req_timer_id,
   input  logic [stq_pkg::DELAY_W-1:0]   req_delay_ticks,
   output logic                          rsp_strobe,
   output logic [stq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [stq_pkg::HANDLE_W-1:0]  rsp_expired_id,
   output logic                          rsp_last,
   output logic [stq_pkg::ACT_W-1:0]     rsp_active_count
);

   import stq_pkg::*;

   `include "sorted_timer_queue_macros.svh"

   localparam int CW    = $clog2(TIMER_SLOTS + 1);
   localparam int AW    = $clog2(TIMER_SLOTS);
   localparam int EW    = TICK_BITS + HANDLE_W;
   localparam int SUM_W = ((TICK_BITS > DELAY_W) ? TICK_BITS : DELAY_W) + 1;
   localparam logic [CW-1:0] SLOTS_C = CW'(TIMER_SLOTS);

   state_type               state_ff, state_in;
   logic [KIND_W-1:0]       kind_ff, kind_in;
   logic [HANDLE_W-1:0]     id_ff, id_in;
   logic [TICK_BITS-1:0]    key_ff, key_in;
   logic [TICK_BITS-1:0]    tick_ff, tick_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           pos_ff, pos_in;
   logic                    found_ff, found_in;
   logic                    pos_set_ff, pos_set_in;
   logic                    pend_ff, pend_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [ACT_W-1:0]        rsp_active_ff, rsp_active_in;

   logic                    accept;
   logic                    full;
   logic [CW-1:0]           idx_dec, idx_inc;
   logic [EW-1:0]           rd_data;
   logic [TICK_BITS-1:0]    rd_exp;
   logic [HANDLE_W-1:0]     rd_hdl;
   logic                    key_le;
   logic                    hdl_match;
   logic [SUM_W-1:0]        sum;
   logic [TICK_BITS-1:0]    expiry_sat;
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   logic [EW-1:0]           mem_wdata;
   logic [AW-1:0]           mem_raddr;

   stq_slot_ram #(
      .DEPTH (TIMER_SLOTS),
      .WIDTH (EW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (rd_data)
   );

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign full       = (cnt_ff >= SLOTS_C);
   assign idx_dec    = idx_ff - CW'(1);
   assign idx_inc    = idx_ff + CW'(1);
   assign rd_exp     = rd_data[EW-1:HANDLE_W];
   assign rd_hdl     = rd_data[HANDLE_W-1:0];
   // the one shared compare unit
   assign key_le     = (rd_exp <= key_ff);
   assign hdl_match  = (rd_hdl == id_ff);
   assign sum        = SUM_W'(tick_ff) + SUM_W'(req_delay_ticks);
   assign expiry_sat = (sum[SUM_W-1:TICK_BITS] != '0) ? '1 : sum[TICK_BITS-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_INSERT || req_kind == KIND_DELETE) begin
                  state_in = S_SCAN_RD;
               end else if (req_kind == KIND_TICK) begin
                  state_in = S_TICK_RD;
               end
            end
         end
         S_SCAN_RD: begin
            state_in = (idx_ff == cnt_ff) ? S_DECIDE : S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            state_in = S_SCAN_RD;
         end
         S_DECIDE: begin
            if (kind_ff == KIND_INSERT) begin
               state_in = (found_ff || full) ? S_IDLE : S_INS_RD;
            end else begin
               state_in = found_ff ? S_DEL_RD : S_IDLE;
            end
         end
         S_INS_RD: begin
            state_in = (idx_ff == pos_ff) ? S_INS_PUT : S_INS_WR;
         end
         S_INS_WR: begin
            state_in = S_INS_RD;
         end
         S_INS_PUT: begin
            state_in = S_IDLE;
         end
         S_DEL_RD: begin
            state_in = (idx_inc >= cnt_ff) ? S_DEL_FIN : S_DEL_WR;
         end
         S_DEL_WR: begin
            state_in = S_DEL_RD;
         end
         S_DEL_FIN: begin
            state_in = (kind_ff == KIND_TICK) ? S_TICK_RD : S_IDLE;
         end
         S_TICK_RD: begin
            state_in = (cnt_ff == '0) ? S_IDLE : S_TICK_CMP;
         end
         S_TICK_CMP: begin
            state_in = key_le ? S_DEL_RD : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath, memory control and results
   always_comb begin
      kind_in       = kind_ff;
      id_in         = id_ff;
      key_in        = key_ff;
      tick_in       = tick_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      found_in      = found_ff;
      pos_set_in    = pos_set_ff;
      pend_in       = pend_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_active_in = rsp_active_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[AW-1:0];
      mem_wdata     = rd_data;
      mem_raddr     = idx_ff[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in    = req_kind;
               id_in      = req_timer_id;
               idx_in     = '0;
               pos_in     = cnt_ff;
               found_in   = 1'b0;
               pos_set_in = 1'b0;
               pend_in    = 1'b0;
               if (req_kind == KIND_INSERT) begin
                  key_in = expiry_sat;
               end else if (req_kind == KIND_TICK) begin
                  tick_in = tick_ff + TICK_BITS'(1);
                  key_in  = tick_ff + TICK_BITS'(1);
               end
            end
         end
         S_SCAN_RD: begin
            mem_raddr = idx_ff[AW-1:0];
         end
         S_SCAN_CMP: begin
            if (hdl_match) begin
               found_in = 1'b1;
               if (kind_ff == KIND_DELETE) begin
                  pos_in = idx_ff;
               end
            end
            if (kind_ff == KIND_INSERT && !key_le && !pos_set_ff) begin
               pos_in     = idx_ff;
               pos_set_in = 1'b1;
            end
            idx_in = idx_inc;
         end
         S_DECIDE: begin
            if (kind_ff == KIND_INSERT) begin
               if (found_ff || full) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = found_ff ? ST_ALREADY : ST_FULL;
                  rsp_id_in     = id_ff;
                  rsp_last_in   = 1'b1;
                  rsp_active_in = ACT_W'(cnt_ff);
               end else begin
                  idx_in = cnt_ff;
               end
            end else begin
               if (!found_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_NOT_QUEUED;
                  rsp_id_in     = id_ff;
                  rsp_last_in   = 1'b1;
                  rsp_active_in = ACT_W'(cnt_ff);
               end else begin
                  idx_in = pos_ff;
               end
            end
         end
         S_INS_RD: begin
            mem_raddr = idx_dec[AW-1:0];
         end
         S_INS_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
            mem_wdata = rd_data;
            idx_in    = idx_dec;
         end
         S_INS_PUT: begin
            mem_we        = 1'b1;
            mem_waddr     = pos_ff[AW-1:0];
            mem_wdata     = {key_ff, id_ff};
            cnt_in        = cnt_ff + CW'(1);
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_OK;
            rsp_id_in     = id_ff;
            rsp_last_in   = 1'b1;
            rsp_active_in = ACT_W'(cnt_ff + CW'(1));
         end
         S_DEL_RD: begin
            mem_raddr = idx_inc[AW-1:0];
         end
         S_DEL_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
            mem_wdata = rd_data;
            idx_in    = idx_inc;
         end
         S_DEL_FIN: begin
            cnt_in = cnt_ff - CW'(1);
            if (kind_ff == KIND_DELETE) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_OK;
               rsp_id_in     = id_ff;
               rsp_last_in   = 1'b1;
               rsp_active_in = ACT_W'(cnt_ff - CW'(1));
            end
         end
         S_TICK_RD: begin
            mem_raddr = '0;
            if (cnt_ff == '0 && pend_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_EXPIRED;
               rsp_id_in     = id_ff;
               rsp_last_in   = 1'b1;
               rsp_active_in = ACT_W'(cnt_ff);
            end
         end
         S_TICK_CMP: begin
            // an expiry is held back until the next head shows whether it is the last
            if (pend_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_EXPIRED;
               rsp_id_in     = id_ff;
               rsp_last_in   = !key_le;
               rsp_active_in = ACT_W'(cnt_ff);
            end
            if (key_le) begin
               pend_in = 1'b1;
               id_in   = rd_hdl;
               idx_in  = '0;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tick_ff       <= '0;
         cnt_ff        <= '0;
         idx_ff        <= '0;
         pos_ff        <= '0;
         found_ff      <= 1'b0;
         pos_set_ff    <= 1'b0;
         pend_ff       <= 1'b0;
         kind_ff       <= KIND_INSERT;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         cnt_ff        <= cnt_in;
         idx_ff        <= idx_in;
         pos_ff        <= pos_in;
         found_ff      <= found_in;
         pos_set_ff    <= pos_set_in;
         pend_ff       <= pend_in;
         kind_ff       <= kind_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_expired_id   = rsp_id_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_active_count = rsp_active_ff;

   `STQ_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff <= SLOTS_C,
                   "timer count above slot count")
   `STQ_ASSERT_IMP(a_cnt_step, clock, reset, 1'b1,
                   cnt_ff == $past(cnt_ff) || cnt_ff == $past(cnt_ff) + CW'(1) ||
                   cnt_ff == $past(cnt_ff) - CW'(1),
                   "timer count moved by more than one")
   `STQ_ASSERT_NXT(a_busy_after_req, clock, reset,
                   accept && (req_kind == KIND_INSERT || req_kind == KIND_DELETE ||
                   req_kind == KIND_TICK), busy, "request taken without going busy")
   `STQ_ASSERT_IMP(a_rsp_from_work, clock, reset, rsp_strobe_ff, $past(busy),
                   "result issued while idle")
   `STQ_ASSERT_IMP(a_single_last, clock, reset, rsp_strobe_ff && rsp_status_ff != ST_EXPIRED,
                   rsp_last_ff, "insert or delete result not marked last")

endmodule
